[rtl/core/lj_pkg.sv]
// ----------------------------------------------------------------------------
// lj_pkg
// Shared types and constants for the Lennard-Jones pair force unit.
// ----------------------------------------------------------------------------
package lj_pkg;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_EPSILON = 2'd0;
    localparam logic [1:0] REG_SIGMA   = 2'd1;
    localparam logic [1:0] REG_CUTOFF  = 2'd2;

    localparam logic [31:0] EPSILON_RST = 32'h0001_0000;
    localparam logic [31:0] SIGMA_RST   = 32'h0001_0000;
    localparam logic [31:0] CUTOFF_RST  = 32'h0003_0000;

    localparam logic signed [47:0] F_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] F_MIN = 48'sh8000_0000_0000;

    // Classified pair as it travels from front to back.
    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        neg_x;
        logic        neg_y;
        logic        live;
        logic        last;
    } lj_pair_t;

    typedef struct packed {
        logic        start;
        logic [63:0] nh;
        logic [63:0] nl;
        logic [63:0] d;
    } lj_div_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] quo;
    } lj_div_rsp_t;

endpackage

[rtl/core/lj_pair_if.sv]
// ----------------------------------------------------------------------------
// lj_pair_if
// Input channel: home and neighbor positions plus last-neighbor mark.
// ----------------------------------------------------------------------------
interface lj_pair_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] atom_x;
    logic signed [31:0] atom_y;
    logic signed [31:0] neighbor_x;
    logic signed [31:0] neighbor_y;
    logic               last_neighbor;

    modport source (output valid, atom_x, atom_y, neighbor_x, neighbor_y, last_neighbor,
                    input ready);
    modport sink   (input valid, atom_x, atom_y, neighbor_x, neighbor_y, last_neighbor,
                    output ready);
endinterface

[rtl/core/lj_force_if.sv]
// ----------------------------------------------------------------------------
// lj_force_if
// Output channel: total force on the home atom and saturation flag.
// ----------------------------------------------------------------------------
interface lj_force_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic               saturated;

    modport source (output valid, force_x, force_y, saturated, input ready);
    modport sink   (input valid, force_x, force_y, saturated, output ready);
endinterface

[rtl/core/lennard_jones_pair_force_unit.sv]
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_unit
// 2D Lennard-Jones 12-6 force accumulator over a stream of neighbor pairs.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | word
//  ----------+-----+---------------+------------------------------------------
//  pair      | in  | valid/ready   | atom_x/y, neighbor_x/y, last_neighbor
//  result    | out | valid/ready   | force_x, force_y, saturated
//  apb       | in  | psel/penable  | epsilon @0x0, sigma @0x4, cutoff @0x8
//
//  A pair inside the cutoff holds the sequencer through ten 64x64 products
//  on one shared 32x32 multiplier, two 64-step divisions (cut short when
//  the quotient saturates), plus the idle, bracket and accumulate states.
//  A pair the front screens out goes from idle straight to accumulate; one
//  rejected on r squared ends at its overflow check or the cutoff compare.
//  Reset is asynchronous, active low, and leaves the registers at
//  epsilon 1.0, sigma 1.0, cutoff 3.0.
//  A two-word queue lets pairs enter while the sequencer works; a waiting
//  result holds only the last pair of the next atom.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    lj_pair_if.sink                   pair,
    lj_force_if.source                result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lj_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import lj_pkg::*;

    logic [31:0] epsilon_reg, sigma_reg, cutoff_reg;
    logic        wr_en;
    lj_pair_t    head;
    logic        head_valid, pop;
    lj_div_req_t div_req;
    lj_div_rsp_t div_rsp;

    // Register file: word address picks the register, unknown index drops writes and reads zero.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= EPSILON_RST;
            sigma_reg   <= SIGMA_RST;
            cutoff_reg  <= CUTOFF_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_EPSILON: epsilon_reg <= pwdata;
                REG_SIGMA:   sigma_reg   <= pwdata;
                REG_CUTOFF:  cutoff_reg  <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_EPSILON: prdata = epsilon_reg;
            REG_SIGMA:   prdata = sigma_reg;
            REG_CUTOFF:  prdata = cutoff_reg;
            default:     prdata = '0;
        endcase
    end

    // Front: distance, cutoff screen, queue.
    lj_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .cutoff     (cutoff_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // Shared divider for sigma^2/r^2 and the force weight.
    lj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back: force terms, accumulation, result register.
    lj_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .epsilon    (epsilon_reg),
        .sigma      (sigma_reg),
        .cutoff     (cutoff_reg),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .result     (result)
    );

endmodule

[rtl/core/lj_front.sv]
// ----------------------------------------------------------------------------
// lj_front
// Accept pair words, form distance magnitudes, classify, and queue them.
// ----------------------------------------------------------------------------
module lj_front (
    input  logic             clk,
    input  logic             rst_n,
    lj_pair_if.sink          pair,
    input  logic [31:0]      cutoff,
    output lj_pkg::lj_pair_t head,
    output logic             head_valid,
    input  logic             pop
);
    import lj_pkg::*;

    logic signed [32:0] dx, dy;
    logic [32:0]        mx, my;
    lj_pair_t           item;
    lj_pair_t           mem [2];
    logic               wptr_reg, rptr_reg;
    logic [1:0]         count_reg;
    logic               push;

    always_comb
    begin
        dx = {pair.atom_x[31], pair.atom_x} - {pair.neighbor_x[31], pair.neighbor_x};
        dy = {pair.atom_y[31], pair.atom_y} - {pair.neighbor_y[31], pair.neighbor_y};
        mx = dx[32] ? 33'(-dx) : 33'(dx);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        item.ax    = mx[31:0];
        item.ay    = my[31:0];
        item.neg_x = dx[32];
        item.neg_y = dy[32];
        item.live  = ((mx | my) != 33'd0) && (mx <= {1'b0, cutoff})
                     && (my <= {1'b0, cutoff});
        item.last  = pair.last_neighbor;
    end

    assign pair.ready = (count_reg != 2'd2);
    assign push       = pair.valid && pair.ready;
    assign head       = mem[rptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/core/lj_div.sv]
// ----------------------------------------------------------------------------
// lj_div
// Restoring 128-by-64 divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module lj_div (
    input  logic                clk,
    input  logic                rst_n,
    input  lj_pkg::lj_div_req_t req,
    output lj_pkg::lj_div_rsp_t rsp
);
    import lj_pkg::*;

    logic        busy_reg, done_reg, sat_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg, nl_reg, d_reg, quo_reg;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb
    begin
        shifted = {rem_reg, nl_reg[63]};
        trial   = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.nh;
            nl_reg  <= req.nl;
            d_reg   <= req.d;
            quo_reg <= (req.nh >= req.d) ? '1 : '0;
            sat_reg <= (req.nh >= req.d);
        end
        else if (busy_reg)
        begin
            nl_reg <= {nl_reg[62:0], 1'b0};
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= (req.nh < req.d);
                done_reg <= (req.nh >= req.d);
                cnt_reg  <= 6'd63;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quo  = quo_reg;

endmodule

[rtl/core/lj_back.sv]
// ----------------------------------------------------------------------------
// lj_back
// Force sequencer: shared 32x32 multiplier, divider, accumulators, result.
// ----------------------------------------------------------------------------
module lj_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lj_pkg::lj_pair_t    head,
    input  logic                head_valid,
    output logic                pop,
    input  logic [31:0]         epsilon,
    input  logic [31:0]         sigma,
    input  logic [31:0]         cutoff,
    output lj_pkg::lj_div_req_t div_req,
    input  lj_pkg::lj_div_rsp_t div_rsp,
    lj_force_if.source          result
);
    import lj_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MX   = 4'd1;
    localparam logic [3:0] S_MY   = 4'd2;
    localparam logic [3:0] S_MC   = 4'd3;
    localparam logic [3:0] S_MS   = 4'd4;
    localparam logic [3:0] S_DQ   = 4'd5;
    localparam logic [3:0] S_M1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_M3   = 4'd8;
    localparam logic [3:0] S_T    = 4'd9;
    localparam logic [3:0] S_ME   = 4'd10;
    localparam logic [3:0] S_DW   = 4'd11;
    localparam logic [3:0] S_MTX  = 4'd12;
    localparam logic [3:0] S_MTY  = 4'd13;
    localparam logic [3:0] S_ACC  = 4'd14;

    logic [3:0]         st_reg;
    logic [2:0]         k_reg;
    logic [63:0]        opa_reg, opb_reg;
    logic [127:0]       acc_reg, mul_acc, pp_sh;
    logic [63:0]        pp;
    lj_pair_t           it_reg;
    logic [63:0]        x2_reg, r2_reg, q_reg, q3_reg, q6_reg;
    logic               tneg_reg, f_reg, add_en_reg;
    logic signed [47:0] term_x_reg, term_y_reg, sum_x_reg, sum_y_reg;
    logic               ovf_reg;
    logic               out_valid_reg, out_sat_reg;
    logic signed [47:0] out_x_reg, out_y_reg;
    logic               in_mul, mul_end;
    logic [64:0]        r2_sum;
    logic [63:0]        mq;
    logic               mq_sat;
    logic [63:0]        tm, tdiff;
    logic [64:0]        tsum;
    logic               tneg, tsat;
    logic [63:0]        e24;
    logic [127:0]       wnum;
    logic [63:0]        tmm;
    logic               tmm_sat, tneg_now;
    logic signed [47:0] term;
    logic               term_sat;
    logic signed [48:0] sx, sy;
    logic signed [47:0] sx_c, sy_c;
    logic               sx_sat, sy_sat;
    logic               emit_ok;
    logic               emit;

    // Multiplier: one partial product per cycle, accumulate into acc.
    always_comb
    begin
        pp = 64'(k_reg[1] ? opa_reg[63:32] : opa_reg[31:0])
           * 64'(k_reg[0] ? opb_reg[63:32] : opb_reg[31:0]);
        case (k_reg)
            3'd0:    pp_sh = {64'd0, pp};
            3'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        mul_acc = ((k_reg == 3'd0) ? 128'd0 : acc_reg) + pp_sh;
    end

    assign in_mul  = (st_reg == S_MX) || (st_reg == S_MY) || (st_reg == S_MC)
                  || (st_reg == S_MS) || (st_reg == S_M1) || (st_reg == S_M2)
                  || (st_reg == S_M3) || (st_reg == S_ME) || (st_reg == S_MTX)
                  || (st_reg == S_MTY);
    assign mul_end = in_mul && (k_reg == 3'd4);

    // Post-processing of a finished product.
    always_comb
    begin
        r2_sum  = {1'b0, x2_reg} + {1'b0, acc_reg[63:0]};
        mq_sat  = (acc_reg[127:96] != 32'd0);
        mq      = mq_sat ? '1 : acc_reg[95:32];
        e24     = ({32'd0, epsilon} << 4) + ({32'd0, epsilon} << 3);
        wnum    = acc_reg << 16;
        tmm_sat = (acc_reg[127:88] != 40'd0);
        tmm     = tmm_sat ? '1 : acc_reg[87:24];
        tneg_now = (st_reg == S_MTX) ? (it_reg.neg_x ^ tneg_reg) : (it_reg.neg_y ^ tneg_reg);
        term_sat = 1'b0;
        if (tneg_now)
        begin
            if (tmm > 64'h0000_8000_0000_0000)
            begin
                term     = F_MIN;
                term_sat = 1'b1;
            end
            else
            begin
                term = 48'(64'd0 - tmm);
            end
        end
        else
        begin
            if (tmm > 64'h0000_7FFF_FFFF_FFFF)
            begin
                term     = F_MAX;
                term_sat = 1'b1;
            end
            else
            begin
                term = 48'(tmm);
            end
        end
    end

    // Bracket 2*q6 - q3 as sign and magnitude.
    always_comb
    begin
        tneg  = 1'b0;
        tsat  = 1'b0;
        tdiff = '0;
        tsum  = '0;
        if (q6_reg >= q3_reg)
        begin
            tdiff = q6_reg - q3_reg;
            tsum  = {1'b0, q6_reg} + {1'b0, tdiff};
            tsat  = tsum[64];
            tm    = tsat ? '1 : tsum[63:0];
        end
        else
        begin
            tdiff = q3_reg - q6_reg;
            if (q6_reg >= tdiff)
            begin
                tm = q6_reg - tdiff;
            end
            else
            begin
                tm   = tdiff - q6_reg;
                tneg = 1'b1;
            end
        end
    end

    // Saturating accumulate.
    always_comb
    begin
        sx = {sum_x_reg[47], sum_x_reg} + (add_en_reg ? {term_x_reg[47], term_x_reg} : 49'sd0);
        sy = {sum_y_reg[47], sum_y_reg} + (add_en_reg ? {term_y_reg[47], term_y_reg} : 49'sd0);
        sx_sat = (sx[48] != sx[47]);
        sy_sat = (sy[48] != sy[47]);
        sx_c = sx_sat ? (sx[48] ? F_MIN : F_MAX) : sx[47:0];
        sy_c = sy_sat ? (sy[48] ? F_MIN : F_MAX) : sy[47:0];
    end

    assign emit_ok = !out_valid_reg || result.ready;
    assign emit    = (st_reg == S_ACC) && it_reg.last && emit_ok;
    assign pop     = (st_reg == S_IDLE) && head_valid;

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.nh    = {32'd0, acc_reg[63:32]};
        div_req.nl    = {acc_reg[31:0], 32'd0};
        div_req.d     = r2_reg;
        if (st_reg == S_MS && mul_end)
        begin
            div_req.start = 1'b1;
        end
        else if (st_reg == S_ME && mul_end)
        begin
            div_req.start = 1'b1;
            div_req.nh    = wnum[127:64];
            div_req.nl    = wnum[63:0];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_mul && !mul_end)
            acc_reg <= mul_acc;
        if (pop)
        begin
            it_reg  <= head;
            opa_reg <= {32'd0, head.ax};
            opb_reg <= {32'd0, head.ax};
        end
        if (mul_end)
        begin
            unique case (st_reg)
                S_MX:
                begin
                    x2_reg  <= acc_reg[63:0];
                    opa_reg <= {32'd0, it_reg.ay};
                    opb_reg <= {32'd0, it_reg.ay};
                end
                S_MY:
                begin
                    r2_reg  <= r2_sum[63:0];
                    opa_reg <= {32'd0, cutoff};
                    opb_reg <= {32'd0, cutoff};
                end
                S_MC:
                begin
                    opa_reg <= {32'd0, sigma};
                    opb_reg <= {32'd0, sigma};
                end
                S_M1:
                begin
                    opa_reg <= mq;
                    opb_reg <= q_reg;
                end
                S_M2:
                begin
                    q3_reg  <= mq;
                    opa_reg <= mq;
                    opb_reg <= mq;
                end
                S_M3:    q6_reg <= mq;
                S_MTX:
                begin
                    term_x_reg <= term;
                    opa_reg    <= {32'd0, it_reg.ay};
                end
                S_MTY:   term_y_reg <= term;
                default: ;
            endcase
        end
        if (st_reg == S_DQ && div_rsp.done)
        begin
            q_reg   <= div_rsp.quo;
            opa_reg <= div_rsp.quo;
            opb_reg <= div_rsp.quo;
        end
        if (st_reg == S_T)
        begin
            tneg_reg <= tneg;
            opa_reg  <= e24;
            opb_reg  <= tm;
        end
        if (st_reg == S_DW && div_rsp.done)
        begin
            opa_reg <= {32'd0, it_reg.ax};
            opb_reg <= div_rsp.quo;
        end
        if (emit)
        begin
            out_x_reg   <= sx_c;
            out_y_reg   <= sy_c;
            out_sat_reg <= ovf_reg | f_reg | sx_sat | sy_sat;
        end
    end

    // Control and accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            k_reg         <= '0;
            f_reg         <= 1'b0;
            add_en_reg    <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a new word, or drop the old one once it is taken.
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (in_mul)
                k_reg <= mul_end ? 3'd0 : k_reg + 3'd1;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        f_reg      <= 1'b0;
                        add_en_reg <= 1'b0;
                        st_reg     <= head.live ? S_MX : S_ACC;
                    end
                end
                S_MX:
                begin
                    if (mul_end)
                        st_reg <= S_MY;
                end
                S_MY:
                begin
                    if (mul_end)
                        st_reg <= r2_sum[64] ? S_ACC : S_MC;
                end
                S_MC:
                begin
                    if (mul_end)
                        st_reg <= (r2_reg > acc_reg[63:0]) ? S_ACC : S_MS;
                end
                S_MS:
                begin
                    if (mul_end)
                        st_reg <= S_DQ;
                end
                S_DQ:
                begin
                    if (div_rsp.done)
                    begin
                        f_reg  <= f_reg | div_rsp.sat;
                        st_reg <= S_M1;
                    end
                end
                S_M1, S_M2:
                begin
                    if (mul_end)
                    begin
                        f_reg  <= f_reg | mq_sat;
                        st_reg <= st_reg + 4'd1;
                    end
                end
                S_M3:
                begin
                    if (mul_end)
                    begin
                        f_reg  <= f_reg | mq_sat;
                        st_reg <= S_T;
                    end
                end
                S_T:
                begin
                    f_reg  <= f_reg | tsat;
                    st_reg <= S_ME;
                end
                S_ME:
                begin
                    if (mul_end)
                        st_reg <= S_DW;
                end
                S_DW:
                begin
                    if (div_rsp.done)
                    begin
                        f_reg  <= f_reg | div_rsp.sat;
                        st_reg <= S_MTX;
                    end
                end
                S_MTX:
                begin
                    if (mul_end)
                    begin
                        f_reg  <= f_reg | tmm_sat | term_sat;
                        st_reg <= S_MTY;
                    end
                end
                S_MTY:
                begin
                    if (mul_end)
                    begin
                        f_reg      <= f_reg | tmm_sat | term_sat;
                        add_en_reg <= 1'b1;
                        st_reg     <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (!it_reg.last)
                    begin
                        sum_x_reg <= sx_c;
                        sum_y_reg <= sy_c;
                        ovf_reg   <= ovf_reg | f_reg | sx_sat | sy_sat;
                        st_reg    <= S_IDLE;
                    end
                    else if (emit_ok)
                    begin
                        sum_x_reg <= '0;
                        sum_y_reg <= '0;
                        ovf_reg   <= 1'b0;
                        st_reg    <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.force_x   = out_x_reg;
    assign result.force_y   = out_y_reg;
    assign result.saturated = out_sat_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (st_reg == S_IDLE))
        else $error("pop outside idle");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_ACC && it_reg.last && emit_ok) |=> out_valid_reg)
        else $error("result not loaded");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_ACC && it_reg.last && emit_ok)
        |=> (sum_x_reg == 48'sd0 && sum_y_reg == 48'sd0 && !ovf_reg))
        else $error("sums not cleared after result");

endmodule

[tb/lennard_jones_pair_force_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_unit_tb
// Streams neighbor pairs through the force unit under several register
// settings and handshake pressures, predicts each emitted force word with a
// bit-exact fixed-point model and compares it field by field.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_unit_tb;
    import lj_pkg::*;

    localparam logic [1:0]  REG_UNUSED  = 2'd3;    // no register decodes here
    localparam int          DRAIN_WAIT  = 1000;    // a few queued live pairs
    localparam int          STALL_LIMIT = 50000;

    typedef struct {
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic               sat;
    } force_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lj_pair_if  pair();
    lj_force_if result();

    lennard_jones_pair_force_unit u_top (
        .clk(clk), .rst_n(rst_n), .pair(pair.sink), .result(result.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Predictor state: register shadows and the running sums
    logic [63:0] eps_q = EPSILON_RST, sig_q = SIGMA_RST, cut_q = CUTOFF_RST;
    longint      acc_fx, acc_fy;
    bit          acc_sat;
    force_word_t pending_forces[$];

    int errors = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int stall_cycles = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Fixed-point helpers: products and quotients truncate and saturate to 64 bits
    // ------------------------------------------------------------------
    function automatic logic [63:0] shift_sat(input logic [127:0] p, input int sh,
                                              inout bit f);
        logic [127:0] s;
        s = p >> sh;
        if (s[127:64] != 0)
        begin
            f = 1;
            return '1;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [63:0] d,
                                            inout bit f);
        logic [127:0] quo;
        if (n[127:64] >= d)
        begin
            f = 1;
            return '1;
        end
        quo = n / {64'b0, d};
        return quo[63:0];
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b,
                                         inout bit f);
        return shift_sat({64'b0, a} * {64'b0, b}, 32, f);
    endfunction

    // One force component, clamped to the 48-bit range
    function automatic longint force_term(input logic [63:0] dmag, input bit neg,
                                          input logic [63:0] w, inout bit f);
        logic [63:0] m;
        m = shift_sat({64'b0, dmag} * {64'b0, w}, 24, f);
        if (neg)
        begin
            if (m > 64'h8000_0000_0000)
            begin
                f = 1;
                return F_MIN;
            end
            return -longint'(m);
        end
        if (m > 64'h7FFF_FFFF_FFFF)
        begin
            f = 1;
            return F_MAX;
        end
        return longint'(m);
    endfunction

    function automatic longint sum_sat(input longint a, input longint b, inout bit f);
        longint s;
        s = a + b;
        if (s > longint'(F_MAX))
        begin
            f = 1;
            return F_MAX;
        end
        if (s < longint'(F_MIN))
        begin
            f = 1;
            return F_MIN;
        end
        return s;
    endfunction

    // Add one pair's force to the sums; on the last neighbor queue the word
    task automatic accumulate_pair(input logic signed [31:0] hx, hy, nx, ny,
                                   input logic last);
        longint      dx, dy;
        logic [63:0] ax, ay, x2, r2, q, q3, q6, tmag, w, dd;
        logic [127:0] num;
        bit          f, tneg;
        force_word_t fw;
        f = 0;
        tneg = 0;
        dx = longint'(hx) - longint'(nx);
        dy = longint'(hy) - longint'(ny);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if ((ax | ay) != 0 && ax <= cut_q && ay <= cut_q)
        begin
            x2 = ax * ax;
            r2 = x2 + ay * ay;
            if (r2 >= x2 && r2 <= cut_q * cut_q)
            begin
                q  = div_sat({64'b0, sig_q * sig_q} << 32, r2, f);
                q3 = qmul(qmul(q, q, f), q, f);
                q6 = qmul(q3, q3, f);
                if (q6 >= q3)
                begin
                    dd = q6 - q3;
                    tmag = q6 + dd;
                    if (tmag < q6)
                    begin
                        tmag = '1;
                        f = 1;
                    end
                end
                else
                begin
                    dd = q3 - q6;
                    if (q6 >= dd)
                        tmag = q6 - dd;
                    else
                    begin
                        tmag = dd - q6;
                        tneg = 1;
                    end
                end
                num = ({64'b0, 64'(24 * eps_q)} * {64'b0, tmag}) << 16;
                w = div_sat(num, r2, f);
                acc_fx = sum_sat(acc_fx, force_term(ax, (dx < 0) != tneg, w, f), f);
                acc_fy = sum_sat(acc_fy, force_term(ay, (dy < 0) != tneg, w, f), f);
            end
        end
        if (f)
            acc_sat = 1;
        if (last)
        begin
            fw.fx = acc_fx[47:0];
            fw.fy = acc_fy[47:0];
            fw.sat = acc_sat;
            pending_forces.insert(pending_forces.size(), fw);
            acc_fx = 0;
            acc_fy = 0;
            acc_sat = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus plumbing
    // ------------------------------------------------------------------
    // Called at a falling edge; returns at a falling edge with the word taken
    task automatic send_pair(input logic signed [31:0] hx, hy, nx, ny, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            pair.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        pair.valid         <= 1'b1;
        pair.atom_x        <= hx;
        pair.atom_y        <= hy;
        pair.neighbor_x    <= nx;
        pair.neighbor_y    <= ny;
        pair.last_neighbor <= last;
        do
            @(posedge clk);
        while (!pair.ready);
        accumulate_pair(hx, hy, nx, ny, last);
        @(negedge clk);
    endtask

    // Drop valid, then hold until every force word is out and the unit is quiet
    task automatic drain;
        pair.valid <= 1'b0;
        wait (pending_forces.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_EPSILON: eps_q = data;
            REG_SIGMA:   sig_q = data;
            REG_CUTOFF:  cut_q = data;
            default: ;
        endcase
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("reg %0d read %h, want %h", idx, prdata, want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain, load all three coefficients, then read them back
    task automatic set_coefficients(input logic [31:0] e, s, c);
        drain();
        apb_write(REG_EPSILON, e);
        apb_write(REG_SIGMA, s);
        apb_write(REG_CUTOFF, c);
        apb_check(REG_EPSILON, e);
        apb_check(REG_SIGMA, s);
        apb_check(REG_CUTOFF, c);
    endtask

    // One home atom with a run of neighbors; mostly inside the cutoff, some noise
    task automatic send_atom(input int nbrs);
        logic signed [31:0] hx, hy;
        longint ox, oy, span;
        hx = $urandom_range(3) == 0 ? $urandom : $signed($urandom) >>> 2;
        hy = $urandom_range(3) == 0 ? $urandom : $signed($urandom) >>> 2;
        span = longint'(cut_q) + longint'(cut_q >> 2) + 1;
        for (int i = 0; i < nbrs; i++)
        begin
            if ($urandom_range(9) == 0)
                send_pair(hx, hy, $urandom, $urandom, i == nbrs - 1);
            else
            begin
                ox = ({$urandom, $urandom} & 64'h1_FFFF_FFFF) % span;
                oy = ({$urandom, $urandom} & 64'h1_FFFF_FFFF) % span;
                if ($urandom_range(1)) ox = -ox;
                if ($urandom_range(1)) oy = -oy;
                send_pair(hx, hy, 32'(longint'(hx) - ox), 32'(longint'(hy) - oy),
                          i == nbrs - 1);
            end
        end
    endtask

    task automatic send_atoms(input int items);
        int n, k;
        n = 0;
        while (n < items)
        begin
            k = $urandom_range(1, 8);
            send_atom(k);
            n += k;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset coefficients: eps 1.0, sigma 1.0, cutoff 3.0
    task automatic test_special_pairs;
        apb_check(REG_EPSILON, EPSILON_RST);
        apb_check(REG_SIGMA, SIGMA_RST);
        apb_check(REG_CUTOFF, CUTOFF_RST);
        send_pair(32'sh1_0000, 32'sh2_0000, 32'sh1_0000, 32'sh2_0000, 1'b0); // coincident
        send_pair(32'sh1_0000, 0, 0, 0, 1'b1);                               // r = 1
        send_pair(0, 0, 32'sh3_0000, 0, 1'b1);                               // on cutoff
        send_pair(0, 0, 32'sh3_0001, 0, 1'b1);                               // just beyond
        send_pair(0, 0, 32'sh1_0000, -32'sh3_0001, 1'b1);                    // y alone out
        send_pair(32'sh1_1999, 32'sh0_8000, 0, 0, 1'b0);                     // attractive
        send_pair(-32'sh1_8000, 0, 0, 32'sh0_4000, 1'b0);                    // attractive
        send_pair(0, 0, 32'sh7000_0000, 0, 1'b1);                            // skipped last
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_pair(0, 0, 0, 0, 1'b1);                                         // all zero
        send_pair(1, 0, 0, 0, 1'b0);                                         // q saturates
        send_pair(0, -1, 0, 0, 1'b0);
        send_pair(32'sh0_0100, 32'sh0_0100, 0, 0, 1'b1);
        // the unused slot takes writes without effect
        drain();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_pair(32'sh1_0000, 0, 0, 0, 1'b1);
    endtask

    // Walk each coefficient to its extremes
    task automatic test_coefficient_extremes;
        set_coefficients(32'hFFFF_FFFF, 32'h0001_0000, 32'h0003_0000);
        send_atoms(30);
        set_coefficients(32'h0000_0000, 32'h0001_0000, 32'h0003_0000);
        send_atoms(20);
        set_coefficients(32'h0001_0000, 32'h0000_0000, 32'h0003_0000);
        send_atoms(20);
        set_coefficients(32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_atoms(30);
        set_coefficients(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
        send_atoms(20);
        set_coefficients(32'h0002_0000, 32'h0000_8000, 32'hFFFF_FFFF);
        send_atoms(30);
    endtask

    // Many strong close pairs per atom so the sums hit their limits
    task automatic test_sum_saturation;
        set_coefficients(32'hFFFF_FFFF, 32'h0010_0000, 32'h0020_0000);
        for (int a = 0; a < 4; a++)
            for (int i = 0; i < 6; i++)
                send_pair(32'sh0001_0000 + $urandom_range(255), -$urandom_range(255),
                          0, 0, i == 5);
    endtask

    // Random coefficients near physical values under one idling pattern
    task automatic test_random_traffic(input int snd, input int rcv, input int items);
        logic [31:0] s;
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        for (int b = 0; b < 4; b++)
        begin
            s = $urandom_range(32'h8000, 32'h2_0000);
            set_coefficients($urandom_range(32'h4000, 32'h4_0000), s,
                             $urandom_range(s, 4 * s));
            send_atoms(items / 4);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver pressure, result checking and the watchdog
    // ------------------------------------------------------------------
    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        force_word_t want;
        if (result.valid && result.ready)
        begin
            if (pending_forces.size() == 0)
                report_mismatch("force word with nothing pending");
            else
            begin
                want = pending_forces.pop_front();
                if (result.force_x !== want.fx)
                    report_mismatch($sformatf("force_x %h, want %h", result.force_x, want.fx));
                if (result.force_y !== want.fy)
                    report_mismatch($sformatf("force_y %h, want %h", result.force_y, want.fy));
                if (result.saturated !== want.sat)
                    report_mismatch($sformatf("saturated %b, want %b",
                                              result.saturated, want.sat));
            end
        end
    end

    // Count cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if ((pair.valid && pair.ready) || (result.valid && result.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL lennard_jones_pair_force_unit");
            $finish;
        end
    end

    initial
    begin
        pair.valid = 1'b0;
        pair.atom_x = '0;
        pair.atom_y = '0;
        pair.neighbor_x = '0;
        pair.neighbor_y = '0;
        pair.last_neighbor = 1'b0;
        result.ready = 1'b0;
        acc_fx = 0;
        acc_fy = 0;
        acc_sat = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_special_pairs();
        test_coefficient_extremes();
        test_sum_saturation();
        test_random_traffic(20, 58, 300);
        test_random_traffic(58, 20, 300);
        test_random_traffic(0, 0, 300);

        pair.valid <= 1'b0;
        wait (pending_forces.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("PASS lennard_jones_pair_force_unit");
        else
            $display("FAIL lennard_jones_pair_force_unit");
        $finish;
    end
endmodule
